>>> hw/rtl/lwd_pkg.sv
`timescale 1ns / 1ps
// Package for the lattice wall-distance labeler: field widths, label codes,
// item modes and the node index wrap function. Depends on nothing.
package lwd_pkg;

  localparam int unsigned IDX_W = 12;
  localparam int unsigned LBL_W = 5;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned DIRF_W = 5;

  localparam int unsigned NODE_COUNT_DEF = 4096;
  localparam int unsigned DIRECTION_COUNT_DEF = 18;

  localparam logic [LBL_W-1:0] LABEL_SOLID = 5'd28;
  localparam logic [LBL_W-1:0] LABEL_NEAR = 5'd1;
  localparam logic [LBL_W-1:0] LABEL_FAR = 5'd2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WR_LABEL = 2'd0,
    MODE_WR_NBR   = 2'd1,
    MODE_RELABEL  = 2'd2,
    MODE_NONE     = 2'd3
  } mode_t;

  // Reduces a 12-bit index modulo count by restoring compare-subtract steps.
  // Only the steps whose scaled count still fits in 12 bits are live.
  function automatic logic [IDX_W-1:0] wrap_index(input logic [IDX_W-1:0] v,
                                                  input int unsigned count);
    logic [31:0] r;
    logic [31:0] m;
    r = 32'(v);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      m = 32'(count) << k;
      if (m < 32'(1 << IDX_W) && r >= m) begin
        r = r - m;
      end
    end
    return r[IDX_W-1:0];
  endfunction

endpackage

>>> hw/rtl/lwd_ram.sv
`timescale 1ns / 1ps
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module lwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/lattice_wall_distance_labeler_unit.sv
`timescale 1ns / 1ps
// Top level of the lattice wall-distance labeler: sequencer around a label
// RAM and a neighbor-table RAM. Depends on lwd_pkg and lwd_ram.
//
// Usage: a word on the in_ ports is taken at a rising edge with start high
// and busy low. Mode 0 writes a node label, mode 1 writes one neighbor
// entry (directions at or above DIRECTION_COUNT are dropped), mode 2
// relabels a node, mode 3 is dropped. Loads keep busy high for one cycle.
// A relabel reads the node label, then for each direction reads the
// neighbor entry, wraps it, reads that node's label and entry, and reads
// the label two steps out only when the first neighbor is not solid. The
// walk is bound by the single read port of the label RAM and the wrap
// stage between table reads. A solid node ends after its label check.
// The result word appears on out_ for one cycle with out_valid high, in the
// first cycle in which busy is low again; the receiver cannot stall it.
// Reset clears the sequencer and the strobe; the RAMs hold unknown data
// until written and need no clearing.
module lattice_wall_distance_labeler_unit #(
  parameter int unsigned NODE_COUNT = lwd_pkg::NODE_COUNT_DEF,
  parameter int unsigned DIRECTION_COUNT = lwd_pkg::DIRECTION_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [lwd_pkg::MODE_W-1:0] in_mode,
  input  logic [lwd_pkg::IDX_W-1:0]  in_node,
  input  logic [lwd_pkg::DIRF_W-1:0] in_direction,
  input  logic [lwd_pkg::IDX_W-1:0]  in_value,
  output logic                       out_valid,
  output logic [lwd_pkg::IDX_W-1:0]  out_node_out,
  output logic [lwd_pkg::LBL_W-1:0]  out_new_label
);

  import lwd_pkg::*;

  localparam int unsigned NODE_W = $clog2(NODE_COUNT);
  localparam int unsigned DIR_W = (DIRECTION_COUNT > 1) ? $clog2(DIRECTION_COUNT) : 1;
  localparam int unsigned TBL_DEPTH = NODE_COUNT * DIRECTION_COUNT;
  localparam int unsigned TBL_AW = $clog2(TBL_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_LBL_RD,
    ST_LBL_CHK,
    ST_N1_RD,
    ST_N1_WRAP,
    ST_ONE_RD,
    ST_ONE_CHK,
    ST_TWO_RD,
    ST_TWO_CHK,
    ST_WB
  } state_t;

  state_t             state_r;
  mode_t              mode_r;
  logic [NODE_W-1:0]  node_r;
  logic [DIR_W-1:0]   dir_r;
  logic [IDX_W-1:0]   value_r;
  logic [DIR_W-1:0]   d_r;
  logic [NODE_W-1:0]  one_r;
  logic [NODE_W-1:0]  two_r;
  logic [LBL_W-1:0]   label_r;
  logic               out_valid_r;
  logic [IDX_W-1:0]   out_node_r;
  logic [LBL_W-1:0]   out_label_r;

  logic               dir_ok;
  logic               last_dir;
  logic [NODE_W-1:0]  tbl_node;
  logic [DIR_W-1:0]   tbl_dir;
  logic [TBL_AW-1:0]  tbl_addr;
  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_rdata;
  logic               lbl_we;
  logic [NODE_W-1:0]  lbl_raddr;
  logic [LBL_W-1:0]   lbl_wdata;
  logic [LBL_W-1:0]   lbl_rdata;
  logic               lbl_solid;

  assign dir_ok = 32'(in_direction) < DIRECTION_COUNT;
  assign last_dir = d_r == DIR_W'(DIRECTION_COUNT - 1);
  assign lbl_solid = lbl_rdata == LABEL_SOLID;

  assign tbl_node = (state_r == ST_ONE_RD) ? one_r : node_r;
  assign tbl_dir = (state_r == ST_LOAD) ? dir_r : d_r;
  assign tbl_addr = TBL_AW'(TBL_AW'(tbl_node) * TBL_AW'(DIRECTION_COUNT)) + TBL_AW'(tbl_dir);
  assign tbl_we = (state_r == ST_LOAD) && (mode_r == MODE_WR_NBR);

  always_comb begin
    unique case (state_r)
      ST_ONE_RD: lbl_raddr = one_r;
      ST_TWO_RD: lbl_raddr = two_r;
      default:   lbl_raddr = node_r;
    endcase
  end

  assign lbl_we = ((state_r == ST_LOAD) && (mode_r == MODE_WR_LABEL)) || (state_r == ST_WB);
  assign lbl_wdata = (state_r == ST_WB) ? label_r : value_r[LBL_W-1:0];

  lwd_ram #(
    .WIDTH(LBL_W),
    .DEPTH(NODE_COUNT)
  ) u_label_ram (
    .clk  (clk),
    .we   (lbl_we),
    .waddr(node_r),
    .wdata(lbl_wdata),
    .raddr(lbl_raddr),
    .rdata(lbl_rdata)
  );

  lwd_ram #(
    .WIDTH(IDX_W),
    .DEPTH(TBL_DEPTH)
  ) u_nbr_ram (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_addr),
    .wdata(value_r),
    .raddr(tbl_addr),
    .rdata(tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            mode_r <= mode_t'(in_mode);
            node_r <= NODE_W'(wrap_index(in_node, NODE_COUNT));
            dir_r <= DIR_W'(in_direction);
            value_r <= in_value;
            unique case (mode_t'(in_mode))
              MODE_WR_LABEL: state_r <= ST_LOAD;
              MODE_WR_NBR:   state_r <= dir_ok ? ST_LOAD : ST_IDLE;
              MODE_RELABEL:  state_r <= ST_LBL_RD;
              default:       state_r <= ST_IDLE;
            endcase
          end
        end
        ST_LOAD: begin
          state_r <= ST_IDLE;
        end
        ST_LBL_RD: begin
          state_r <= ST_LBL_CHK;
        end
        ST_LBL_CHK: begin
          label_r <= lbl_rdata;
          d_r <= '0;
          if (lbl_solid) begin
            out_valid_r <= 1'b1;
            out_node_r <= IDX_W'(node_r);
            out_label_r <= LABEL_SOLID;
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_N1_RD;
          end
        end
        ST_N1_RD: begin
          state_r <= ST_N1_WRAP;
        end
        ST_N1_WRAP: begin
          one_r <= NODE_W'(wrap_index(tbl_rdata, NODE_COUNT));
          state_r <= ST_ONE_RD;
        end
        ST_ONE_RD: begin
          state_r <= ST_ONE_CHK;
        end
        ST_ONE_CHK: begin
          if (lbl_solid) begin
            label_r <= LABEL_NEAR;
            d_r <= d_r + 1'b1;
            state_r <= last_dir ? ST_WB : ST_N1_RD;
          end else begin
            two_r <= NODE_W'(wrap_index(tbl_rdata, NODE_COUNT));
            state_r <= ST_TWO_RD;
          end
        end
        ST_TWO_RD: begin
          state_r <= ST_TWO_CHK;
        end
        ST_TWO_CHK: begin
          if (lbl_solid) begin
            label_r <= LABEL_FAR;
          end
          d_r <= d_r + 1'b1;
          state_r <= last_dir ? ST_WB : ST_N1_RD;
        end
        ST_WB: begin
          out_valid_r <= 1'b1;
          out_node_r <= IDX_W'(node_r);
          out_label_r <= label_r;
          state_r <= ST_IDLE;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_node_out = out_node_r;
  assign out_new_label = out_label_r;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the lattice wall-distance labeler: directed words, then
// random node regions with relabel sweeps, checked against an in-bench predictor.
// Depends on lwd_pkg and lattice_wall_distance_labeler_unit.
module testbench;
  import lwd_pkg::*;

  localparam int unsigned NODES = NODE_COUNT_DEF;
  localparam int unsigned DIRS = DIRECTION_COUNT_DEF;
  localparam int RANDOM_WORDS = 600;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [IDX_W-1:0] node;
    logic [LBL_W-1:0] label;
  } relabel_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [MODE_W-1:0] in_mode;
  logic [IDX_W-1:0] in_node;
  logic [DIRF_W-1:0] in_direction;
  logic [IDX_W-1:0] in_value;
  logic out_valid;
  logic [IDX_W-1:0] out_node_out;
  logic [LBL_W-1:0] out_new_label;

  logic [LBL_W-1:0] label_mem [NODES];
  logic [IDX_W-1:0] link_mem [NODES][DIRS];
  bit label_set [NODES];
  bit link_set [NODES][DIRS];
  relabel_t label_due_q [$];

  int mismatches = 0;
  int words_applied = 0;
  int gap_pct = 25;
  int stall_cycles = 0;

  lattice_wall_distance_labeler_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_node      (in_node),
    .in_direction (in_direction),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_node_out (out_node_out),
    .out_new_label(out_new_label)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic logic [LBL_W-1:0] settle_label(input logic [IDX_W-1:0] n);
    logic [LBL_W-1:0] lbl;
    logic [IDX_W-1:0] one;
    logic [IDX_W-1:0] two;
    lbl = label_mem[n];
    if (lbl != LABEL_SOLID) begin
      for (int d = 0; d < DIRS; d++) begin
        one = link_mem[n][d];
        if (label_mem[one] == LABEL_SOLID) begin
          lbl = LABEL_NEAR;
        end else begin
          two = link_mem[one][d];
          if (label_mem[two] == LABEL_SOLID) begin
            lbl = LABEL_FAR;
          end
        end
      end
    end
    return lbl;
  endfunction

  // True when every entry that a relabel of n may read has been written.
  function automatic bit walk_is_known(input logic [IDX_W-1:0] n);
    logic [IDX_W-1:0] one;
    if (!label_set[n]) return 1'b0;
    if (label_mem[n] == LABEL_SOLID) return 1'b1;
    for (int d = 0; d < DIRS; d++) begin
      if (!link_set[n][d]) return 1'b0;
      one = link_mem[n][d];
      if (!label_set[one] || !link_set[one][d]) return 1'b0;
      if (label_mem[one] != LABEL_SOLID && !label_set[link_mem[one][d]]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] pick_label_word();
    logic [LBL_W-1:0] lbl;
    lbl = ($urandom_range(0, 2) == 0) ? LABEL_SOLID : LBL_W'($urandom_range(0, 31));
    return {7'($urandom_range(0, 127)), lbl};
  endfunction

  // Sends one word, waits for it to be taken and updates the predicted stores.
  task automatic send_word(input mode_t m, input logic [IDX_W-1:0] n,
                           input logic [DIRF_W-1:0] d, input logic [IDX_W-1:0] v);
    logic [LBL_W-1:0] lbl;
    if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_node <= n;
    in_direction <= d;
    in_value <= v;
    do @(posedge clk); while (busy !== 1'b0);
    case (m)
      MODE_WR_LABEL: begin
        label_mem[n] = v[LBL_W-1:0];
        label_set[n] = 1'b1;
        words_applied++;
      end
      MODE_WR_NBR: begin
        if (d < DIRS) begin
          link_mem[n][d] = v;
          link_set[n][d] = 1'b1;
          words_applied++;
        end
      end
      MODE_RELABEL: begin
        lbl = settle_label(n);
        label_mem[n] = lbl;
        label_due_q.push_back('{node: n, label: lbl});
        words_applied++;
      end
      default: begin
      end
    endcase
  endtask

  task automatic relabel_node(input logic [IDX_W-1:0] n);
    if (walk_is_known(n)) begin
      send_word(MODE_RELABEL, n, DIRF_W'($urandom_range(0, 31)), IDX_W'($urandom_range(0, 4095)));
    end
  endtask

  task automatic test_solid_node();
    send_word(MODE_WR_LABEL, 12'h000, 5'd31, 12'hFFC);
    relabel_node(12'h000);
  endtask

  task automatic test_ignored_words();
    send_word(MODE_NONE, 12'hFFF, 5'd31, 12'hFFF);
    send_word(MODE_WR_NBR, 12'hFFF, 5'd18, 12'h000);
    send_word(MODE_WR_NBR, 12'hFFF, 5'd31, 12'hFFF);
  endtask

  task automatic test_direction_order();
    send_word(MODE_WR_LABEL, 12'hFFF, 5'd0, 12'hFE5);
    for (int d = 0; d < DIRS; d++) begin
      send_word(MODE_WR_NBR, 12'hFFF, DIRF_W'(d),
                (d == 3) ? 12'h000 : (d == DIRS - 1) ? 12'h001 : 12'hFFF);
    end
    send_word(MODE_WR_NBR, 12'h000, 5'd3, 12'h000);
    send_word(MODE_WR_LABEL, 12'h001, 5'd0, 12'h007);
    send_word(MODE_WR_NBR, 12'h001, DIRF_W'(DIRS - 1), 12'h000);
    relabel_node(12'hFFF);
    relabel_node(12'hFFF);
    send_word(MODE_WR_NBR, 12'hFFF, DIRF_W'(DIRS - 1), 12'hFFF);
    relabel_node(12'hFFF);
  endtask

  task automatic test_random_regions();
    logic [IDX_W-1:0] region [$];
    logic [IDX_W-1:0] cand;
    int base;
    int region_size;
    int k1;
    int k2;
    int pick;
    bit dup;
    base = words_applied;
    while (words_applied - base < RANDOM_WORDS) begin
      if (words_applied - base > RANDOM_WORDS * 4 / 5) begin
        gap_pct = 0;
      end else begin
        gap_pct = 25 * $urandom_range(0, 2);
      end
      region.delete();
      region_size = $urandom_range(2, 5);
      while (region.size() < region_size) begin
        if ($urandom_range(0, 7) == 0) begin
          cand = ($urandom_range(0, 1) == 1) ? 12'hFFF : 12'h000;
        end else begin
          cand = IDX_W'($urandom_range(0, 4095));
        end
        dup = 1'b0;
        foreach (region[i]) if (region[i] == cand) dup = 1'b1;
        if (!dup) region.push_back(cand);
      end
      foreach (region[i]) send_word(MODE_WR_LABEL, region[i], 5'd0, pick_label_word());
      foreach (region[i]) begin
        for (int d = 0; d < DIRS; d++) begin
          send_word(MODE_WR_NBR, region[i], DIRF_W'(d),
                    region[$urandom_range(0, region_size - 1)]);
        end
      end
      repeat ($urandom_range(30, 60)) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          relabel_node(region[$urandom_range(0, region_size - 1)]);
        end else if (pick < 50) begin
          k1 = $urandom_range(0, region_size - 1);
          k2 = $urandom_range(k1, region_size - 1);
          for (int k = k1; k <= k2; k++) relabel_node(region[k]);
        end else if (pick < 65) begin
          send_word(MODE_WR_LABEL, region[$urandom_range(0, region_size - 1)],
                    DIRF_W'($urandom_range(0, 31)), pick_label_word());
        end else if (pick < 78) begin
          send_word(MODE_WR_NBR, region[$urandom_range(0, region_size - 1)],
                    DIRF_W'($urandom_range(0, DIRS - 1)),
                    region[$urandom_range(0, region_size - 1)]);
        end else begin
          case ($urandom_range(0, 3))
            0: send_word(MODE_NONE, IDX_W'($urandom_range(0, 4095)),
                         DIRF_W'($urandom_range(0, 31)), IDX_W'($urandom_range(0, 4095)));
            1: send_word(MODE_WR_NBR, IDX_W'($urandom_range(0, 4095)),
                         DIRF_W'($urandom_range(DIRS, 31)), IDX_W'($urandom_range(0, 4095)));
            2: send_word(($urandom_range(0, 1) == 1) ? MODE_WR_NBR : MODE_WR_LABEL,
                         IDX_W'($urandom_range(0, 4095)), DIRF_W'($urandom_range(0, DIRS - 1)),
                         IDX_W'($urandom_range(0, 4095)));
            default: relabel_node(IDX_W'($urandom_range(0, 4095)));
          endcase
        end
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    relabel_t due;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (label_due_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result node %0d label %0d",
                                out_node_out, out_new_label));
      end else begin
        due = label_due_q.pop_front();
        if (out_node_out !== due.node) begin
          flag_mismatch($sformatf("node_out %0d, expected %0d", out_node_out, due.node));
        end
        if (out_new_label !== due.label) begin
          flag_mismatch($sformatf("new_label %0d for node %0d, expected %0d",
                                  out_new_label, due.node, due.label));
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_mode <= MODE_NONE;
    in_node <= '0;
    in_direction <= '0;
    in_value <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_solid_node();
    test_ignored_words();
    test_direction_order();
    test_random_regions();
    start <= 1'b0;
    while (label_due_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
